@@ src/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants, types and codes for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lpr_pkg;

   localparam int MaxFrames   = 16;
   localparam int PageWidth   = 16;
   localparam int FaultWidth  = 16;
   localparam int FramesWidth = 5;
   localparam int SlotWidth   = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
   localparam int CountWidth  = $clog2(MaxFrames + 1);

   localparam logic [FramesWidth-1:0] ResetFrames = FramesWidth'(4);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_DONE
   } state_type;

   // Access to the recency chain memory.
   typedef struct packed {
      logic                 wr_en;
      logic [SlotWidth-1:0] wr_addr;
      logic [PageWidth-1:0] wr_data;
      logic                 rd_en;
      logic [SlotWidth-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic                  hit;
      logic                  evicted;
      logic [PageWidth-1:0]  evicted_page;
      logic [FaultWidth-1:0] fault_count;
   } result_type;

endpackage

@@ src/lpr_chain_ram.sv @@
// ----------------------------------------------------------------------------
// LRU recency chain memory
// One write and one registered read per cycle; slot 0 is the most recent page.
// ----------------------------------------------------------------------------
module lpr_chain_ram
   import lpr_pkg::*;
(
   input  logic                 clock,
   input  ram_req_type          ram_req,
   output logic [PageWidth-1:0] rd_data
);

   logic [PageWidth-1:0] mem [MaxFrames];
   logic [PageWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/lpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// LRU chain controller
// Walks the recency chain one slot per cycle, compares and shifts it in place,
// and keeps the fill count and the saturating fault count.
// ----------------------------------------------------------------------------
module lpr_ctrl
   import lpr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [FramesWidth-1:0] frames_cfg,
   input  logic                   item_valid,
   output logic                   item_ready,
   input  logic [PageWidth-1:0]   item_page,
   input  logic                   item_last,
   output ram_req_type            ram_req,
   input  logic [PageWidth-1:0]   rd_data,
   output logic                   done_valid,
   input  logic                   done_ready,
   output result_type             done_result
);

   state_type state_ff, state_in;

   logic [PageWidth-1:0]  page_ff, page_in;
   logic                  last_ff, last_in;
   logic [PageWidth-1:0]  carry_ff, carry_in;
   logic [SlotWidth-1:0]  idx_ff, idx_in;
   logic [CountWidth-1:0] live_ff, live_in;
   logic [CountWidth-1:0] nf_ff, nf_in;
   logic                  full_ff, full_in;
   logic [CountWidth-1:0] filled_ff, filled_in;
   logic [FaultWidth-1:0] faults_ff, faults_in;
   logic                  hit_ff, hit_in;
   logic                  ev_ff, ev_in;
   logic [PageWidth-1:0]  ev_page_ff, ev_page_in;

   logic [CountWidth-1:0] usable;
   logic [CountWidth-1:0] live_now;
   logic                  accept;
   logic                  match;
   logic                  at_end;
   logic                  finish;
   logic [FaultWidth-1:0] faults_next;

   // A frame setting of zero acts as one, and one above the chain depth as the depth.
   always_comb begin
      if (frames_cfg == '0) begin
         usable = CountWidth'(1);
      end else if (CountWidth'(frames_cfg) > CountWidth'(MaxFrames)) begin
         usable = CountWidth'(MaxFrames);
      end else begin
         usable = CountWidth'(frames_cfg);
      end
   end

   assign live_now = (filled_ff < usable) ? filled_ff : usable;
   assign accept   = item_valid && item_ready;
   assign match    = (rd_data == page_ff);
   assign at_end   = ((CountWidth'(idx_ff) + CountWidth'(1)) == live_ff);
   assign finish   = done_valid && done_ready;

   always_comb begin
      if (!hit_ff && (faults_ff != '1)) begin
         faults_next = faults_ff + FaultWidth'(1);
      end else begin
         faults_next = faults_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (live_now == '0) ? ST_APPEND : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match) begin
               state_in = ST_DONE;
            end else if (at_end) begin
               state_in = full_ff ? ST_DONE : ST_APPEND;
            end
         end
         ST_APPEND: state_in = ST_DONE;
         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and memory accesses.
   always_comb begin
      item_ready      = 1'b0;
      done_valid      = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = idx_ff;
      ram_req.wr_data = carry_ff;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = idx_ff + SlotWidth'(1);
      case (state_ff)
         ST_IDLE: begin
            item_ready      = 1'b1;
            ram_req.rd_en   = item_valid;
            ram_req.rd_addr = '0;
         end
         ST_SCAN: begin
            // The slot just read takes the page that was one place ahead of it.
            ram_req.wr_en = 1'b1;
            ram_req.rd_en = !match && !at_end;
         end
         ST_APPEND: ram_req.wr_en = 1'b1;
         ST_DONE:   done_valid    = 1'b1;
         default: begin
            item_ready = 1'b0;
         end
      endcase
   end

   assign done_result.hit          = hit_ff;
   assign done_result.evicted      = ev_ff;
   assign done_result.evicted_page = ev_page_ff;
   assign done_result.fault_count  = faults_next;

   // Datapath next values.
   always_comb begin
      page_in    = page_ff;
      last_in    = last_ff;
      carry_in   = carry_ff;
      idx_in     = idx_ff;
      live_in    = live_ff;
      nf_in      = nf_ff;
      full_in    = full_ff;
      filled_in  = filled_ff;
      faults_in  = faults_ff;
      hit_in     = hit_ff;
      ev_in      = ev_ff;
      ev_page_in = ev_page_ff;
      if (accept) begin
         page_in    = item_page;
         last_in    = item_last;
         carry_in   = item_page;
         idx_in     = '0;
         live_in    = live_now;
         nf_in      = usable;
         full_in    = (filled_ff >= usable);
         hit_in     = 1'b0;
         ev_in      = 1'b0;
         ev_page_in = '0;
      end
      if (state_ff == ST_SCAN) begin
         if (match) begin
            hit_in = 1'b1;
         end else if (at_end && full_ff) begin
            ev_in      = 1'b1;
            ev_page_in = rd_data;
         end else begin
            carry_in = rd_data;
            idx_in   = idx_ff + SlotWidth'(1);
         end
      end
      if (finish) begin
         faults_in = faults_next;
         if (!hit_ff) begin
            filled_in = full_ff ? nf_ff : filled_ff + CountWidth'(1);
         end
         if (last_ff) begin
            faults_in = '0;
            filled_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         filled_ff <= '0;
         faults_ff <= '0;
      end else begin
         state_ff  <= state_in;
         filled_ff <= filled_in;
         faults_ff <= faults_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff    <= page_in;
      last_ff    <= last_in;
      carry_ff   <= carry_in;
      idx_ff     <= idx_in;
      live_ff    <= live_in;
      nf_ff      <= nf_in;
      full_ff    <= full_in;
      hit_ff     <= hit_in;
      ev_ff      <= ev_in;
      ev_page_ff <= ev_page_in;
   end

`ifndef SYNTHESIS
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      done_valid |-> !(done_result.hit && done_result.evicted))
      else $error("hit and eviction reported together");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (finish && last_ff) |=> (filled_ff == '0 && faults_ff == '0))
      else $error("end of string did not clear the chain");

   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      (done_valid && ev_ff) |-> (full_ff && !hit_ff))
      else $error("eviction while a free frame was left");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr))
      else $error("read and write of the same chain slot in one cycle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      finish |=> (filled_ff <= CountWidth'(MaxFrames)))
      else $error("fill count beyond the chain depth");
`endif

endmodule

@@ src/lru_page_replacement_top.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement
// Keeps resident pages in recency order and reports hits, evictions and faults.
// ----------------------------------------------------------------------------
// Each page reference is handled by walking the recency chain, which lives in
// a single-port-read memory, one slot per cycle from the most recent page on.
// A hit ends the walk at the page's chain position. A miss walks all L live
// slots, where L is the smaller of the filled frames and the frame setting;
// with all frames full the last page is evicted, else the page is appended
// in a free frame by a further write step. A result waits in an output
// register, so the next reference is taken while it is held. No clearing
// pass follows reset. The frame setting must be written only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lru_page_replacement_top
   import lpr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Page reference stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // [15:0] page
   input  logic                   req_tlast,   // last_of_string
   // Result stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // [15:0] evicted_page, [31:16] fault_count
   output logic [1:0]             rsp_tuser,   // [0] hit, [1] evicted
   // Frame setting.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [FramesWidth-1:0] csr_wdata    // frames_in_use
);

   logic [FramesWidth-1:0] frames_ff, frames_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff, rsp_data_in;

   ram_req_type            ram_req;
   logic [PageWidth-1:0]   rd_data;
   logic                   done_valid;
   logic                   done_ready;
   result_type             done_result;

   assign csr_ready = 1'b1;
   assign frames_in = (csr_valid && csr_ready) ? csr_wdata : frames_ff;

   lpr_chain_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   lpr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .frames_cfg  (frames_ff),
      .item_valid  (req_tvalid),
      .item_ready  (req_tready),
      .item_page   (req_tdata[PageWidth-1:0]),
      .item_last   (req_tlast),
      .ram_req     (ram_req),
      .rd_data     (rd_data),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_result (done_result)
   );

   assign done_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= ResetFrames;
         rsp_valid_ff <= 1'b0;
      end else begin
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.fault_count, rsp_data_ff.evicted_page};
   assign rsp_tuser  = {rsp_data_ff.evicted, rsp_data_ff.hit};

endmodule
